/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/skec_pkg.sv */
// ----------------------------------------------------------------------------
// skec_pkg
// Shared types and constants of the sampled keyed event counter.
// ----------------------------------------------------------------------------
package skec_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  // Register indexes of the configuration port.
  localparam logic [1:0] RegSampleRate   = 2'd0;
  localparam logic [1:0] RegFilterEnable = 2'd1;
  localparam logic [1:0] RegTargetGroup  = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    StFiltered = 2'd0,
    StSampled  = 2'd1,
    StCounted  = 2'd2,
    StFull     = 2'd3
  } status_e;

  // Request and reply between the sequencer and the modulo unit.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic        is_zero;
  } mod_rsp_t;

endpackage

/* rtl/skec_mod_unit.sv */
// ----------------------------------------------------------------------------
// skec_mod_unit
// Bit-serial restoring remainder of a 64-bit value by a 32-bit divisor.
// ----------------------------------------------------------------------------
module skec_mod_unit
  import skec_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic [63:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  // One quotient bit per cycle: shift in a dividend bit and try subtracting.
  always_comb begin
    shifted = {rem_q[31:0], dvd_q[63]};
    diff    = shifted - {1'b0, dvs_q};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      rem_d = diff[32] ? shifted : diff;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.is_zero = (rem_q == '0);

endmodule

/* rtl/sampled_keyed_event_counter_unit.sv */
// ----------------------------------------------------------------------------
// sampled_keyed_event_counter_unit
// Filters fault events, samples one in N, and counts kept events per key.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+-------------------
//  event    | start_i, busy_o, group_id_i, ...         | start_i && !busy_o
//  result   | result_valid_o, status_o, new_count_o    | result_valid_o
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i    | cfg_valid_i && cfg_ready_o
//
// A filtered event goes from the transfer straight to SDone, which shows its
// result. A passing event runs the 64-iteration modulo; a sampled-out one then
// goes to SDone. A kept event probes occupied slots in SScanRd and SScanCmp (one
// probe when the table is empty, up to 4096), then writes in SUpdate unless full.
// Slots fill in order from zero and are never freed, so a fill count stands
// for the valid bits; reset clears it and the sample counter, no clear pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sampled_keyed_event_counter_unit
  import skec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] group_id_i,
  input  logic [63:0] ancestor_id_i,
  input  logic        fault_kind_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] new_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    SIdle, SMod, SScanRd, SScanCmp, SUpdate, SDone
  } state_e;

  state_e        state_q;
  logic [31:0]   rate_q;
  logic          filt_q;
  logic [63:0]   target_q;
  logic [63:0]   samp_q;
  logic [63:0]   grp_q;
  logic          kind_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] fill_q;
  logic          ins_q;
  logic [1:0]    status_q;
  logic [63:0]   count_q;
  logic          res_q;
  mod_req_t      mreq;
  mod_rsp_t      mrsp;

  // Table memory: one write and one registered read per cycle.
  logic [64:0]   mem_key [TableEntries];
  logic [63:0]   mem_cnt [TableEntries];
  logic [64:0]   rd_key_q;
  logic [63:0]   rd_cnt_q;
  logic          we;
  logic [IdxW-1:0] waddr;
  logic [63:0]   wcnt;
  logic [IdxW-1:0] ridx;

  assign ridx = idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_key[waddr] <= {grp_q, kind_q};
      mem_cnt[waddr] <= wcnt;
    end
    rd_key_q <= mem_key[ridx];
    rd_cnt_q <= mem_cnt[ridx];
  end

  // Modulo request on entry to the sampling step.
  always_comb begin
    mreq.start    = (state_q == SIdle) && start_i &&
                    !(filt_q && !(ancestor_id_i != '0 && ancestor_id_i == target_q));
    mreq.dividend = samp_q + 64'd1;
    mreq.divisor  = (rate_q == '0) ? 32'd1 : rate_q;
  end

  skec_mod_unit u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  // Only slots below the fill count hold a key.
  logic hit;
  assign hit = (idx_q < fill_q) && (rd_key_q == {grp_q, kind_q});

  // A new key goes to the first free slot, a found key back to its own slot.
  always_comb begin
    we    = 1'b0;
    waddr = ridx;
    wcnt  = count_q;
    if (state_q == SUpdate) begin
      we = 1'b1;
      if (ins_q) begin
        waddr = fill_q[IdxW-1:0];
      end
    end
  end

  // Sequencer: filter, modulo, linear scan, update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      rate_q    <= 32'd1;
      filt_q    <= 1'b1;
      target_q  <= '0;
      samp_q    <= '0;
      fill_q    <= '0;
      ins_q     <= 1'b0;
      res_q     <= 1'b0;
      status_q  <= StFiltered;
      count_q   <= '0;
      idx_q     <= '0;
      grp_q     <= '0;
      kind_q    <= 1'b0;
    end else begin
      res_q <= 1'b0;
      if (cfg_valid_i && state_q == SIdle) begin
        unique case (cfg_index_i)
          RegSampleRate:   rate_q   <= cfg_data_i[31:0];
          RegFilterEnable: filt_q   <= cfg_data_i[0];
          RegTargetGroup:  target_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        SIdle: begin
          if (start_i) begin
            grp_q  <= group_id_i;
            kind_q <= fault_kind_i;
            if (mreq.start) begin
              samp_q <= samp_q + 64'd1;
              state_q <= SMod;
            end else begin
              status_q <= StFiltered;
              count_q  <= '0;
              state_q  <= SDone;
            end
          end
        end
        SMod: begin
          if (mrsp.done) begin
            if (mrsp.is_zero) begin
              idx_q   <= '0;
              state_q <= SScanRd;
            end else begin
              status_q <= StSampled;
              count_q  <= '0;
              state_q  <= SDone;
            end
          end
        end
        SScanRd: state_q <= SScanCmp;
        SScanCmp: begin
          if (hit) begin
            status_q <= StCounted;
            count_q  <= rd_cnt_q + 64'd1;
            ins_q    <= 1'b0;
            state_q  <= SUpdate;
          end else if (idx_q + CntW'(1) >= fill_q) begin
            // Every occupied slot has been probed without a match.
            if (fill_q != CntW'(TableEntries)) begin
              status_q <= StCounted;
              count_q  <= 64'd1;
              ins_q    <= 1'b1;
              state_q  <= SUpdate;
            end else begin
              status_q <= StFull;
              count_q  <= '0;
              state_q  <= SDone;
            end
          end else begin
            idx_q   <= idx_q + CntW'(1);
            state_q <= SScanRd;
          end
        end
        SUpdate: begin
          if (ins_q) begin
            fill_q <= fill_q + CntW'(1);
          end
          state_q <= SDone;
        end
        SDone: begin
          res_q   <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o         = (state_q != SIdle);
  assign cfg_ready_o    = (state_q == SIdle);
  assign result_valid_o = res_q;
  assign status_o       = status_q;
  assign new_count_o    = count_q;

  `ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "busy not raised after start")
  `ASSERT_IMPL(a_res_idle, result_valid_o, !busy_o, "result while busy")
  `ASSERT_IMPL(a_cnt_zero, result_valid_o && status_o != StCounted, new_count_o == '0,
               "nonzero count on uncounted result")

endmodule

/* verif/sampled_keyed_event_counter_unit_tb.sv */
// ----------------------------------------------------------------------------
// sampled_keyed_event_counter_unit_tb
// Drives fault events and register writes into the event counter. Each
// transfer is run through a behavioral model of the filter, the sampler and
// the per-key count table, and every result is checked against it in order.
// ----------------------------------------------------------------------------
module sampled_keyed_event_counter_unit_tb;
  import skec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 is not a register; writes to it must have no effect.
  localparam logic [1:0] RegNone = 2'd3;
  localparam logic [63:0] AllOnes = '1;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned PhaseEvents = 50;
  localparam int unsigned NumGroups = 16;

  typedef enum logic { RowEvent, RowConfig } row_op_e;

  // One line of the directed table: an event or a register write.
  typedef struct {
    row_op_e     op;
    logic [63:0] group;
    logic [63:0] anc;
    logic        kind;
    logic [1:0]  reg_idx;
    logic [63:0] reg_data;
    bit          typed;
    status_e     exp_status;
    logic [63:0] exp_count;
  } row_t;

  typedef struct {
    status_e     status;
    logic [63:0] count;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] group_id_i;
  logic [63:0] ancestor_id_i;
  logic        fault_kind_i;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [63:0] new_count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  // Shadow registers and state of the counter.
  logic [31:0] rate_q;
  logic        filter_q;
  logic [63:0] target_q;
  logic [63:0] pass_count;
  logic [63:0] key_count [logic [64:0]];

  outcome_t    outcome_q[$];
  int unsigned errors;
  int unsigned events_sent;
  int unsigned results_seen;
  int unsigned counted_seen;
  int unsigned cfg_writes;
  bit          idle_free;
  logic [63:0] group_pool [NumGroups];

  sampled_keyed_event_counter_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .group_id_i     (group_id_i),
    .ancestor_id_i  (ancestor_id_i),
    .fault_kind_i   (fault_kind_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .new_count_o    (new_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("sampled_keyed_event_counter_unit_tb NOT OK");
    $finish;
  end

  // Filter, sample and count one event, as the block should.
  function automatic outcome_t count_event(logic [63:0] group, logic [63:0] anc,
                                           logic kind);
    outcome_t    res;
    logic [63:0] rate;
    logic [64:0] key;
    res.status = StFiltered;
    res.count  = '0;
    key = {kind, group};
    if (filter_q && !(anc != '0 && anc == target_q)) return res;
    pass_count = pass_count + 64'd1;
    rate = (rate_q == '0) ? 64'd1 : {32'd0, rate_q};
    if (pass_count % rate != '0) begin
      res.status = StSampled;
      return res;
    end
    if (!key_count.exists(key)) begin
      if (key_count.num() >= TableEntries) begin
        res.status = StFull;
        return res;
      end
      key_count[key] = '0;
    end
    key_count[key] = key_count[key] + 64'd1;
    res.status = StCounted;
    res.count  = key_count[key];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // Present one event until it is taken; returns at the transfer edge.
  task automatic send_event(logic [63:0] group, logic [63:0] anc, logic kind,
                            bit typed, outcome_t typed_res);
    outcome_t res;
    start_i       <= 1'b1;
    group_id_i    <= group;
    ancestor_id_i <= anc;
    fault_kind_i  <= kind;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    res = count_event(group, anc, kind);
    if (typed && (res.status != typed_res.status || res.count != typed_res.count)) begin
      $error("directed row disagrees with model: status %0d/%0d count %0d/%0d",
             typed_res.status, res.status, typed_res.count, res.count);
      errors++;
    end
    outcome_q.push_back(typed ? typed_res : res);
    events_sent++;
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = pick_gap();
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Register write, issued only once the block has drained.
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegSampleRate:   rate_q   = data[31:0];
      RegFilterEnable: filter_q = data[0];
      RegTargetGroup:  target_q = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Result checker: compares each shown result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      outcome_t want;
      results_seen++;
      if (outcome_q.size() == 0) begin
        $error("unexpected result: status %0d count %0d", status_o, new_count_o);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (status_o != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (new_count_o != want.count) begin
          $error("new_count: expected %0d, got %0d", want.count, new_count_o);
          errors++;
        end
        if (status_o == StCounted) counted_seen++;
      end
    end
  end

  initial begin
    row_t        rows[$];
    outcome_t    o;
    logic [63:0] tgt, anc;
    logic [31:0] rate;
    int unsigned r, wait_cycles;

    start_i       = 1'b0;
    group_id_i    = '0;
    ancestor_id_i = '0;
    fault_kind_i  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegSampleRate;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    rate_q        = 32'd1;
    filter_q      = 1'b1;
    target_q      = '0;
    pass_count    = '0;
    errors        = 0;
    events_sent   = 0;
    results_seen  = 0;
    counted_seen  = 0;
    cfg_writes    = 0;
    idle_free     = 1'b0;

    // Group ids: extremes, stripes and random values, so every bit toggles.
    group_pool[0] = '0;
    group_pool[1] = AllOnes;
    group_pool[2] = 64'h5555_5555_5555_5555;
    group_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int i = 4; i < NumGroups; i++) group_pool[i] = {$urandom(), $urandom()};

    // Directed table. With the reset target of zero, every filtered event
    // fails; the zero rate then keeps every passing event.
    rows = '{
      '{RowEvent, '0, '0, 1'b0, RegNone, '0, 1'b1, StFiltered, '0},
      '{RowEvent, AllOnes, AllOnes, 1'b1, RegNone, '0, 1'b1, StFiltered, '0},
      '{RowEvent, AllOnes, '0, 1'b1, RegNone, '0, 1'b1, StFiltered, '0},
      '{RowConfig, '0, '0, 1'b0, RegTargetGroup, AllOnes, 1'b0, StFiltered, '0},
      '{RowConfig, '0, '0, 1'b0, RegSampleRate, '0, 1'b0, StFiltered, '0},
      '{RowEvent, AllOnes, AllOnes, 1'b1, RegNone, '0, 1'b1, StCounted, 64'd1},
      '{RowEvent, AllOnes, AllOnes, 1'b1, RegNone, '0, 1'b1, StCounted, 64'd2},
      '{RowEvent, AllOnes, AllOnes, 1'b0, RegNone, '0, 1'b1, StCounted, 64'd1},
      '{RowEvent, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, RegNone, '0, 1'b1, StFiltered, '0},
      '{RowEvent, '0, '0, 1'b0, RegNone, '0, 1'b1, StFiltered, '0},
      '{RowEvent, '0, AllOnes, 1'b0, RegNone, '0, 1'b1, StCounted, 64'd1},
      '{RowConfig, '0, '0, 1'b0, RegNone, AllOnes, 1'b0, StFiltered, '0},
      '{RowConfig, '0, '0, 1'b0, RegSampleRate, 64'd3, 1'b0, StFiltered, '0},
      '{RowEvent, '0, AllOnes, 1'b0, RegNone, '0, 1'b0, StFiltered, '0},
      '{RowEvent, '0, AllOnes, 1'b0, RegNone, '0, 1'b0, StFiltered, '0},
      '{RowEvent, '0, AllOnes, 1'b0, RegNone, '0, 1'b0, StFiltered, '0},
      '{RowConfig, '0, '0, 1'b0, RegFilterEnable, '0, 1'b0, StFiltered, '0},
      '{RowConfig, '0, '0, 1'b0, RegSampleRate, 64'hFFFF_FFFF, 1'b0, StFiltered, '0},
      '{RowEvent, 64'h5555_5555_5555_5555, '0, 1'b1, RegNone, '0, 1'b0, StFiltered, '0},
      '{RowEvent, 64'hAAAA_AAAA_AAAA_AAAA, 64'd123, 1'b0, RegNone, '0, 1'b0,
        StFiltered, '0},
      '{RowConfig, '0, '0, 1'b0, RegSampleRate, 64'd1, 1'b0, StFiltered, '0},
      '{RowEvent, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, RegNone, '0, 1'b0, StFiltered, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].op == RowConfig) begin
        write_reg(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        o.status = rows[i].exp_status;
        o.count  = rows[i].exp_count;
        send_event(rows[i].group, rows[i].anc, rows[i].kind, rows[i].typed, o);
        idle_gap();
      end
    end

    // Random phases, each under its own register setting. Most events
    // match the target so they reach the sampler and the table.
    for (int p = 0; p < NumPhases; p++) begin
      r = $urandom_range(0, 6);
      case (r)
        0: rate = '0;
        1: rate = 32'd1;
        2: rate = 32'd2;
        3: rate = 32'd3;
        4: rate = $urandom_range(4, 9);
        5: rate = (p == NumPhases - 1) ? 32'hFFFF_FFFF : $urandom();
        default: rate = 32'd1;
      endcase
      tgt = ($urandom_range(0, 9) == 0) ? '0 : group_pool[$urandom_range(0, NumGroups - 1)];
      write_reg(RegSampleRate, {$urandom(), rate});
      write_reg(RegFilterEnable, {{63{1'b1}}, ($urandom_range(0, 3) != 0)});
      write_reg(RegTargetGroup, tgt);
      idle_free = (p % 4 == 1);
      for (int k = 0; k < PhaseEvents; k++) begin
        r = $urandom_range(0, 9);
        if (r < 8) anc = tgt;
        else if (r < 9) anc = '0;
        else anc = {$urandom(), $urandom()};
        o.status = StFiltered;
        o.count  = '0;
        send_event(group_pool[$urandom_range(0, NumGroups - 1)], anc,
                   1'($urandom_range(0, 1)), 1'b0, o);
        idle_gap();
      end
    end

    // Drain the remaining results, then let the block settle.
    start_i <= 1'b0;
    wait_cycles = 0;
    while (outcome_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      errors++;
    end

    $display("Ran %0d events under %0d register writes; %0d results, %0d counted.",
             events_sent, cfg_writes, results_seen, counted_seen);
    $display("Table held %0d keys at the end.", key_count.num());
    if (errors == 0) begin
      $display("sampled_keyed_event_counter_unit_tb OK");
    end else begin
      $display("sampled_keyed_event_counter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/skec_pkg.sv
rtl/skec_mod_unit.sv
rtl/sampled_keyed_event_counter_unit.sv
verif/sampled_keyed_event_counter_unit_tb.sv
